@@ design/pbpe_pkg.sv @@
// Package for the palette blit pixel engine: commands, register indexes,
// table sizes and the structs passed between the top level and the sequencer.
// Depends on nothing.
`default_nettype none

package pbpe_pkg;

  localparam int BLEND_ROWS   = 256;
  localparam int FADE_MAX     = 63;

  localparam int PIX_W        = 8;
  localparam int CMD_W        = 2;
  localparam int IDX_W        = 16;
  localparam int FADE_COUNT_W = 6;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 8;

  localparam int TBL_DEPTH    = 256;
  localparam int TBL_AW       = 8;
  localparam int BLEND_DEPTH  = BLEND_ROWS * TBL_DEPTH;
  localparam int BLEND_AW     = (BLEND_DEPTH > 1) ? $clog2(BLEND_DEPTH) : 1;
  localparam int FADE_CW      = $clog2(FADE_MAX + 1);

  localparam logic [PIX_W-1:0] OPAQUE_CLASS = 8'hFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_PIXEL = 2'd0,
    CMD_CLASS = 2'd1,
    CMD_FADE  = 2'd2,
    CMD_BLEND = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GHOST       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE        = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_COUNT  = 8'd3;

  typedef struct packed {
    logic                    transparent_enable;
    logic                    ghost_enable;
    logic                    fade_enable;
    logic [FADE_COUNT_W-1:0] fade_count;
  } cfg_t;

  typedef struct packed {
    logic                class_we;
    logic [TBL_AW-1:0]   class_addr;
    logic                fade_we;
    logic [TBL_AW-1:0]   fade_addr;
    logic                blend_we;
    logic [BLEND_AW-1:0] blend_addr;
    logic [PIX_W-1:0]    wdata;
  } mem_req_t;

endpackage

`default_nettype wire

@@ design/pbpe_ram.sv @@
// Generic single-port RAM with one write or read address per cycle and a
// registered read. Used for every table of the pixel engine. No dependencies.
`default_nettype none

module pbpe_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ design/pbpe_ctrl.sv @@
// Sequencer of the pixel engine: decodes a request, drives the table RAM
// ports and iterates the fade lookup one pass per cycle.
// Depends on pbpe_pkg.
`default_nettype none

module pbpe_ctrl
  import pbpe_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CMD_W-1:0]    in_command,
  input  wire logic [PIX_W-1:0]    in_src_pixel,
  input  wire logic [PIX_W-1:0]    in_dst_pixel,
  input  wire logic [IDX_W-1:0]    in_table_index,
  input  wire logic [PIX_W-1:0]    in_table_value,
  input  wire cfg_t                cfg,
  output mem_req_t                 mem_req,
  input  wire logic [PIX_W-1:0]    class_rdata,
  input  wire logic [PIX_W-1:0]    fade_rdata,
  input  wire logic [PIX_W-1:0]    blend_rdata,
  output logic                     out_valid,
  output logic                     out_write_enable,
  output logic [PIX_W-1:0]         out_pixel
);

  typedef enum logic [5:0] {
    ST_IDLE       = 6'b000001,
    ST_DECODE     = 6'b000010,
    ST_CLASS      = 6'b000100,
    ST_BLEND      = 6'b001000,
    ST_FADE_ISSUE = 6'b010000,
    ST_FADE_RUN   = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r;
  logic [PIX_W-1:0]    src_r;
  logic [PIX_W-1:0]    dst_r;
  logic [IDX_W-1:0]    idx_r;
  logic [PIX_W-1:0]    val_r;
  logic [PIX_W-1:0]    pix_r, pix_nxt;
  logic [FADE_CW-1:0]  cnt_r, cnt_nxt;
  logic                valid_r, valid_nxt;
  logic                we_r, we_nxt;
  logic [PIX_W-1:0]    opix_r, opix_nxt;
  logic [FADE_CW-1:0]  fade_n;
  logic                fade_go;
  logic                accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign fade_n  = ({2'b00, cfg.fade_count} > (FADE_COUNT_W + 2)'(FADE_MAX)) ?
                   FADE_CW'(FADE_MAX) : FADE_CW'(cfg.fade_count);
  assign fade_go = cfg.fade_enable && (fade_n != '0);

  always_comb begin
    state_nxt = state_r;
    pix_nxt   = pix_r;
    cnt_nxt   = cnt_r;
    valid_nxt = 1'b0;
    we_nxt    = we_r;
    opix_nxt  = opix_r;
    mem_req   = '0;
    mem_req.wdata      = val_r;
    mem_req.class_addr = idx_r[TBL_AW-1:0];
    mem_req.fade_addr  = idx_r[TBL_AW-1:0];
    mem_req.blend_addr = idx_r[BLEND_AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cnt_nxt = fade_n;
        case (cmd_t'(cmd_r))
          CMD_CLASS: begin
            mem_req.class_we = (idx_r < IDX_W'(TBL_DEPTH));
            state_nxt = ST_IDLE;
            valid_nxt = 1'b1;
            we_nxt    = 1'b0;
            opix_nxt  = '0;
          end
          CMD_FADE: begin
            mem_req.fade_we = (idx_r < IDX_W'(TBL_DEPTH));
            state_nxt = ST_IDLE;
            valid_nxt = 1'b1;
            we_nxt    = 1'b0;
            opix_nxt  = '0;
          end
          CMD_BLEND: begin
            mem_req.blend_we = ({1'b0, idx_r} < (IDX_W + 1)'(BLEND_DEPTH));
            state_nxt = ST_IDLE;
            valid_nxt = 1'b1;
            we_nxt    = 1'b0;
            opix_nxt  = '0;
          end
          default: begin
            if (cfg.transparent_enable && (src_r == '0)) begin
              state_nxt = ST_IDLE;
              valid_nxt = 1'b1;
              we_nxt    = 1'b0;
              opix_nxt  = dst_r;
            end else if (cfg.ghost_enable) begin
              mem_req.class_addr = src_r;
              state_nxt = ST_CLASS;
            end else if (fade_go) begin
              pix_nxt   = src_r;
              state_nxt = ST_FADE_ISSUE;
            end else begin
              state_nxt = ST_IDLE;
              valid_nxt = 1'b1;
              we_nxt    = 1'b1;
              opix_nxt  = src_r;
            end
          end
        endcase
      end
      ST_CLASS: begin
        if ((class_rdata != OPAQUE_CLASS) &&
            ({1'b0, class_rdata} < (PIX_W + 1)'(BLEND_ROWS))) begin
          mem_req.blend_addr = BLEND_AW'({class_rdata, dst_r});
          state_nxt = ST_BLEND;
        end else begin
          pix_nxt = (class_rdata == OPAQUE_CLASS) ? src_r : '0;
          if (fade_go) begin
            state_nxt = ST_FADE_ISSUE;
          end else begin
            state_nxt = ST_IDLE;
            valid_nxt = 1'b1;
            we_nxt    = 1'b1;
            opix_nxt  = pix_nxt;
          end
        end
      end
      ST_BLEND: begin
        pix_nxt = blend_rdata;
        if (fade_go) begin
          state_nxt = ST_FADE_ISSUE;
        end else begin
          state_nxt = ST_IDLE;
          valid_nxt = 1'b1;
          we_nxt    = 1'b1;
          opix_nxt  = blend_rdata;
        end
      end
      ST_FADE_ISSUE: begin
        mem_req.fade_addr = pix_r;
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = ST_FADE_RUN;
      end
      ST_FADE_RUN: begin
        if (cnt_r == '0) begin
          state_nxt = ST_IDLE;
          valid_nxt = 1'b1;
          we_nxt    = 1'b1;
          opix_nxt  = fade_rdata;
        end else begin
          mem_req.fade_addr = fade_rdata;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      src_r <= in_src_pixel;
      dst_r <= in_dst_pixel;
      idx_r <= in_table_index;
      val_r <= in_table_value;
    end
    pix_r  <= pix_nxt;
    cnt_r  <= cnt_nxt;
    we_r   <= we_nxt;
    opix_r <= opix_nxt;
  end

  assign out_valid        = valid_r;
  assign out_write_enable = we_r;
  assign out_pixel        = opix_r;

  a_accept_decodes : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_DECODE))
    else $error("accepted request did not enter decode");

  a_result_follows_work : assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> $past(state_r != ST_IDLE))
    else $error("result strobe without a request in progress");

  a_single_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> !valid_r)
    else $error("result strobe lasted more than one cycle");

  a_fade_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FADE_RUN) |-> (cnt_r < FADE_CW'(FADE_MAX)))
    else $error("fade pass counter out of range");

endmodule

`default_nettype wire

@@ design/palette_blit_pixel_engine_unit.sv @@
// Top level of the palette blit pixel engine: configuration registers, the
// class, fade and blend table RAMs and the sequencer.
// Depends on pbpe_pkg, pbpe_ram and pbpe_ctrl.
//
// Usage: a request is taken when start is high and busy is low. Command 0 is
// a pixel (in_src_pixel, in_dst_pixel); commands 1, 2 and 3 load a class, fade
// or blend table entry at in_table_index with in_table_value. Each request
// gives exactly one result, shown for one cycle with out_valid high; there is
// no back-pressure on the result side. Busy falls in the cycle in which the
// result is shown, so a new request may be given then.
// A load, a transparent skip or a pixel with neither translucency nor fading
// shows its result straight from the decode state. A translucent lookup adds
// a class read and a blend read, an opaque class only the class read. Fading
// adds an issue state and then one fade table read per pass, up to the value
// of the fade count register (at most 63 passes).
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and should be written only while the engine is idle.
// Reset clears the configuration registers and the sequencer's state and
// result strobe; table contents are undefined until loaded.
`default_nettype none

module palette_blit_pixel_engine_unit
  import pbpe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [CMD_W-1:0]      in_command,
  input  wire logic [PIX_W-1:0]      in_src_pixel,
  input  wire logic [PIX_W-1:0]      in_dst_pixel,
  input  wire logic [IDX_W-1:0]      in_table_index,
  input  wire logic [PIX_W-1:0]      in_table_value,
  output logic                       out_valid,
  output logic                       out_write_enable,
  output logic [PIX_W-1:0]           out_pixel,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t             cfg_r;
  mem_req_t         mem_req;
  logic [PIX_W-1:0] class_rdata;
  logic [PIX_W-1:0] fade_rdata;
  logic [PIX_W-1:0] blend_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TRANSPARENT: cfg_r.transparent_enable <= cfg_data[0];
        REG_GHOST:       cfg_r.ghost_enable       <= cfg_data[0];
        REG_FADE:        cfg_r.fade_enable        <= cfg_data[0];
        REG_FADE_COUNT:  cfg_r.fade_count         <= cfg_data[FADE_COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pbpe_ram #(.WIDTH(PIX_W), .DEPTH(TBL_DEPTH)) u_class_ram (
    .clk   (clk),
    .we    (mem_req.class_we),
    .addr  (mem_req.class_addr),
    .wdata (mem_req.wdata),
    .rdata (class_rdata)
  );

  pbpe_ram #(.WIDTH(PIX_W), .DEPTH(TBL_DEPTH)) u_fade_ram (
    .clk   (clk),
    .we    (mem_req.fade_we),
    .addr  (mem_req.fade_addr),
    .wdata (mem_req.wdata),
    .rdata (fade_rdata)
  );

  pbpe_ram #(.WIDTH(PIX_W), .DEPTH(BLEND_DEPTH), .ADDR_W(BLEND_AW)) u_blend_ram (
    .clk   (clk),
    .we    (mem_req.blend_we),
    .addr  (mem_req.blend_addr),
    .wdata (mem_req.wdata),
    .rdata (blend_rdata)
  );

  pbpe_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_src_pixel     (in_src_pixel),
    .in_dst_pixel     (in_dst_pixel),
    .in_table_index   (in_table_index),
    .in_table_value   (in_table_value),
    .cfg              (cfg_r),
    .mem_req          (mem_req),
    .class_rdata      (class_rdata),
    .fade_rdata       (fade_rdata),
    .blend_rdata      (blend_rdata),
    .out_valid        (out_valid),
    .out_write_enable (out_write_enable),
    .out_pixel        (out_pixel)
  );

endmodule

`default_nettype wire
